### rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

   // request codes
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [2:0] REQ_POP_BACK   = 3'd3;
   localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
   localparam logic [2:0] REQ_PEEK_BACK  = 3'd5;

   // field widths
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 11;

   // answer for a pop or peek on an empty queue
   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

   typedef struct packed {
      logic [2:0]               req_type;
      logic signed [DATA_W-1:0] push_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [COUNT_W-1:0]       entry_count;
      logic                     is_empty;
      logic                     push_dropped;
   } rsp_payload_type;

endpackage

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// A result beat appears on rsp_strobe in the cycle after its request is taken.
// Throughput: one request per cycle; the memory takes one write and one registered
// read per cycle, so a push is visible to the very next request.
// Reset: synchronous, clears the front pointer and the entry count; slot contents are
// left as they are. busy is high only while reset is held. The receiver cannot stall.

module double_ended_queue #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  deq_pkg::req_payload_type req_payload,
   output logic                     rsp_strobe,
   output deq_pkg::rsp_payload_type rsp_payload
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic                       accept;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [deq_pkg::DATA_W-1:0] wr_data;
   logic [AW-1:0]              rd_addr;
   logic [deq_pkg::DATA_W-1:0] rd_data;

   // no request is taken while reset is held
   assign busy   = reset;
   assign accept = start && !busy;

   deq_ctrl #(
      .DEPTH(DEPTH),
      .AW   (AW),
      .CW   (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_payload(req_payload),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   deq_ram #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule

### rtl/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [deq_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [deq_pkg::DATA_W-1:0] rd_data
);

   logic [deq_pkg::DATA_W-1:0] slots_ff [DEPTH];
   logic [deq_pkg::DATA_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slots_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int CW    = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  deq_pkg::req_payload_type   req_payload,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [deq_pkg::DATA_W-1:0] wr_data,
   output logic [AW-1:0]              rd_addr,
   input  logic [deq_pkg::DATA_W-1:0] rd_data,
   output logic                       rsp_strobe,
   output deq_pkg::rsp_payload_type   rsp_payload
);

   localparam int PW = AW + 1;
   localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
   localparam int WW = (CW > deq_pkg::COUNT_W) ? CW : deq_pkg::COUNT_W;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic          strobe_ff;
   logic          use_mem_ff, use_mem_in;
   logic          neg_ff, neg_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] count_ff;

   logic          is_full;
   logic          is_empty;
   logic [PW-1:0] back_sum, last_sum, next_sum;
   logic [AW-1:0] back_pos, last_pos, head_next, head_prev;
   logic [WW-1:0] count_wide;

   // ring positions around the front pointer
   assign is_full  = (occ_ff == CW'(DEPTH));
   assign is_empty = (occ_ff == '0);
   assign back_sum = PW'(head_ff) + PW'(occ_ff);
   assign last_sum = back_sum - PW'(1);
   assign next_sum = PW'(head_ff) + PW'(1);
   assign back_pos  = (back_sum >= DEPTH_P) ? AW'(back_sum - DEPTH_P) : AW'(back_sum);
   assign last_pos  = (last_sum >= DEPTH_P) ? AW'(last_sum - DEPTH_P) : AW'(last_sum);
   assign head_next = (next_sum >= DEPTH_P) ? AW'(next_sum - DEPTH_P) : AW'(next_sum);
   assign head_prev = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);

   assign wr_data = deq_pkg::DATA_W'(req_payload.push_value);

   // request decode, pointer update, memory access
   always_comb begin
      head_in    = head_ff;
      occ_in     = occ_ff;
      wr_en      = 1'b0;
      wr_addr    = back_pos;
      rd_addr    = head_ff;
      use_mem_in = 1'b0;
      neg_in     = 1'b0;
      dropped_in = 1'b0;
      if (accept) begin
         unique case (req_payload.req_type)
            deq_pkg::REQ_PUSH_FRONT: begin
               if (is_full) begin
                  dropped_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = head_prev;
                  head_in = head_prev;
                  occ_in  = occ_ff + CW'(1);
               end
            end
            deq_pkg::REQ_PUSH_BACK: begin
               if (is_full) begin
                  dropped_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = back_pos;
                  occ_in  = occ_ff + CW'(1);
               end
            end
            deq_pkg::REQ_POP_FRONT: begin
               rd_addr = head_ff;
               if (is_empty) begin
                  neg_in = 1'b1;
               end else begin
                  use_mem_in = 1'b1;
                  head_in    = head_next;
                  occ_in     = occ_ff - CW'(1);
               end
            end
            deq_pkg::REQ_POP_BACK: begin
               rd_addr = last_pos;
               if (is_empty) begin
                  neg_in = 1'b1;
               end else begin
                  use_mem_in = 1'b1;
                  occ_in     = occ_ff - CW'(1);
               end
            end
            deq_pkg::REQ_PEEK_FRONT: begin
               rd_addr    = head_ff;
               neg_in     = is_empty;
               use_mem_in = !is_empty;
            end
            deq_pkg::REQ_PEEK_BACK: begin
               rd_addr    = last_pos;
               neg_in     = is_empty;
               use_mem_in = !is_empty;
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         occ_ff    <= occ_in;
         strobe_ff <= accept;
      end
   end

   // result stage, aligned with the memory read data
   always_ff @(posedge clock) begin
      use_mem_ff <= use_mem_in;
      neg_ff     <= neg_in;
      dropped_ff <= dropped_in;
      count_ff   <= occ_in;
   end

   assign count_wide = WW'(count_ff);

   always_comb begin
      if (use_mem_ff) begin
         rsp_payload.result_value = signed'(rd_data);
      end else if (neg_ff) begin
         rsp_payload.result_value = deq_pkg::EMPTY_VALUE;
      end else begin
         rsp_payload.result_value = '0;
      end
      rsp_payload.entry_count  = count_wide[deq_pkg::COUNT_W-1:0];
      rsp_payload.is_empty     = (count_ff == '0);
      rsp_payload.push_dropped = dropped_ff;
   end

   assign rsp_strobe = strobe_ff;

endmodule

### rtl/deq_checker.sv
`timescale 1ns / 1ps

module deq_checker #(
   parameter int DEPTH = 1024
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input deq_pkg::req_payload_type req_payload,
   input logic                     rsp_strobe,
   input deq_pkg::rsp_payload_type rsp_payload
);

   localparam int WW = ($clog2(DEPTH + 1) > deq_pkg::COUNT_W) ?
                       $clog2(DEPTH + 1) : deq_pkg::COUNT_W;
   localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);
   localparam logic [deq_pkg::COUNT_W-1:0] FULL_COUNT = DEPTH_W[deq_pkg::COUNT_W-1:0];

   // every taken request gives exactly one beat, in the following cycle
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(start && !busy))
      else $error("result beat does not follow its request");

   // empty flag agrees with the count it is reported with
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.is_empty == (rsp_payload.entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   // a dropped push leaves a full queue and answers zero
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.push_dropped) |->
         (rsp_payload.entry_count == FULL_COUNT && rsp_payload.result_value == '0))
      else $error("dropped push without a full queue");

   // only pushes can be dropped: a non-push request is never flagged as dropped
   a_push_value: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.req_type != deq_pkg::REQ_PUSH_FRONT &&
       req_payload.req_type != deq_pkg::REQ_PUSH_BACK) |=> !rsp_payload.push_dropped)
      else $error("non-push request flagged as dropped");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
